/* design/hash_inner_join_engine_defines.svh */
// ----------------------------------------------------------------------------
// hash inner join engine assertion macros
// concurrent check helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef HASH_INNER_JOIN_ENGINE_DEFINES_SVH
`define HASH_INNER_JOIN_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HIJE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hije check failed");
`define HIJE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hije check failed");
`else
`define HIJE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HIJE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/hije_pkg.sv */
// ----------------------------------------------------------------------------
// hije_pkg
// shared types and constants of the hash inner join engine
// ----------------------------------------------------------------------------
package hije_pkg;

    localparam int ROW_DEPTH_DEF    = 64;
    localparam int BUCKET_DEPTH_DEF = 128;
    localparam int RESULT_LIMIT     = 64;
    localparam int MIN_BUCKET_BITS  = 3;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int MIX_SH1 = 30;
    localparam int MIX_SH2 = 27;
    localparam int MIX_SH3 = 31;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    localparam logic [2:0] BUCKET_BITS_RST = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_SUM_A,
        S_MUL_B,
        S_SUM_B,
        S_HEAD,
        S_HEAD_Q,
        S_ROW_RD,
        S_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic clr;
        logic emit_full;
        logic emit_exh;
        logic mul;
        logic mul_sel;
        logic sum;
        logic bucket;
        logic build_wr;
        logic walk_init;
        logic cmp;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic exhausted;
        logic is_build;
        logic head_valid;
        logic more;
    } t_sts;

endpackage

/* design/hash_inner_join_engine.sv */
// ----------------------------------------------------------------------------
// hash_inner_join_engine
// chained hash join over 64-bit keys with splitmix64 bucket hashing
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Clear, a build into a
// full table and a probe with an exhausted counter finish in the cycle they are
// taken. A build runs the split 64-bit multiplies and sums of the hash, then the
// bucket head ram read, then links the row in. A probe runs the same hash and
// head read, then walks the chain, where each row costs a row store read and a
// key compare. Results appear on o_valid for one cycle each, in the cycle after
// they are formed; the receiver cannot stall, so no result is ever held back.
// Matches come newest row first and the final one carries o_last.
// ----------------------------------------------------------------------------
`include "hash_inner_join_engine_defines.svh"

module hash_inner_join_engine #(
    parameter int ROW_DEPTH    = hije_pkg::ROW_DEPTH_DEF,
    parameter int BUCKET_DEPTH = hije_pkg::BUCKET_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic signed [63:0] i_key,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_wdata,
    output logic               o_valid,
    output logic [31:0]        o_left_index,
    output logic [5:0]         o_right_index,
    output logic               o_matched,
    output logic               o_last,
    output logic [1:0]         o_status
);

    hije_pkg::t_cmd cmd;
    hije_pkg::t_sts sts;
    logic           res_err;
    logic           clr_take;

    hije_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    hije_dp #(
        .ROW_DEPTH    (ROW_DEPTH),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_left_index  (o_left_index),
        .o_right_index (o_right_index),
        .o_matched     (o_matched),
        .o_last        (o_last),
        .o_status      (o_status)
    );

    assign res_err  = o_valid && (o_status != hije_pkg::ST_OK);
    assign clr_take = start && !busy && (i_opcode == hije_pkg::OP_CLEAR);

    `HIJE_ASSERT_IMP(a_err_is_last, i_clk, i_rst_n, res_err, o_last && !o_matched)
    `HIJE_ASSERT_IMP(a_match_ok, i_clk, i_rst_n, o_valid && o_matched, o_status == hije_pkg::ST_OK)
    `HIJE_ASSERT_NXT(a_clear_silent, i_clk, i_rst_n, clr_take, !o_valid && !busy)

endmodule

/* design/hije_ram.sv */
// ----------------------------------------------------------------------------
// hije_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hije_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/hije_ctrl.sv */
// ----------------------------------------------------------------------------
// hije_ctrl
// sequencer for hashing, build insert and chain walk
// ----------------------------------------------------------------------------
module hije_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_opcode,
    input  hije_pkg::t_sts   i_sts,
    output hije_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    hije_pkg::t_state r_state;
    hije_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hije_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            hije_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_opcode)
                        hije_pkg::OP_CLEAR: begin
                            o_cmd.clr = 1'b1;
                        end
                        hije_pkg::OP_BUILD: begin
                            if (i_sts.full) begin
                                o_cmd.emit_full = 1'b1;
                            end else begin
                                o_cmd.load = 1'b1;
                                n_state    = hije_pkg::S_MUL_A;
                            end
                        end
                        hije_pkg::OP_PROBE: begin
                            if (i_sts.exhausted) begin
                                o_cmd.emit_exh = 1'b1;
                            end else begin
                                o_cmd.load = 1'b1;
                                n_state    = hije_pkg::S_MUL_A;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            hije_pkg::S_MUL_A: begin
                o_cmd.mul = 1'b1;
                n_state   = hije_pkg::S_SUM_A;
            end
            hije_pkg::S_SUM_A: begin
                o_cmd.sum = 1'b1;
                n_state   = hije_pkg::S_MUL_B;
            end
            hije_pkg::S_MUL_B: begin
                o_cmd.mul     = 1'b1;
                o_cmd.mul_sel = 1'b1;
                n_state       = hije_pkg::S_SUM_B;
            end
            hije_pkg::S_SUM_B: begin
                o_cmd.sum = 1'b1;
                n_state   = hije_pkg::S_HEAD;
            end
            hije_pkg::S_HEAD: begin
                o_cmd.bucket = 1'b1;
                n_state      = hije_pkg::S_HEAD_Q;
            end
            hije_pkg::S_HEAD_Q: begin
                if (i_sts.is_build) begin
                    o_cmd.build_wr = 1'b1;
                    n_state        = hije_pkg::S_IDLE;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state = i_sts.head_valid ? hije_pkg::S_ROW_RD : hije_pkg::S_FIN;
                end
            end
            hije_pkg::S_ROW_RD: begin
                n_state = hije_pkg::S_CMP;
            end
            hije_pkg::S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.more ? hije_pkg::S_ROW_RD : hije_pkg::S_FIN;
            end
            hije_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = hije_pkg::S_IDLE;
            end
            default: begin
                n_state = hije_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != hije_pkg::S_IDLE);

endmodule

/* design/hije_dp.sv */
// ----------------------------------------------------------------------------
// hije_dp
// hash pipeline, bucket heads, row store, counters and result register
// ----------------------------------------------------------------------------
module hije_dp #(
    parameter int ROW_DEPTH    = hije_pkg::ROW_DEPTH_DEF,
    parameter int BUCKET_DEPTH = hije_pkg::BUCKET_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hije_pkg::t_cmd      i_cmd,
    output hije_pkg::t_sts      o_sts,
    input  logic [1:0]          i_opcode,
    input  logic signed [63:0]  i_key,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_wdata,
    output logic                o_valid,
    output logic [31:0]         o_left_index,
    output logic [5:0]          o_right_index,
    output logic                o_matched,
    output logic                o_last,
    output logic [1:0]          o_status
);

    localparam int RW  = $clog2(ROW_DEPTH);
    localparam int BKW = $clog2(BUCKET_DEPTH);
    localparam int NMW = $clog2(hije_pkg::RESULT_LIMIT + 1);
    localparam logic [RW:0]    ROW_FULL  = (RW + 1)'(ROW_DEPTH);
    localparam logic [RW:0]    STEP_LAST = (RW + 1)'(ROW_DEPTH - 1);
    localparam logic [NMW-1:0] NM_LIMIT  = NMW'(hije_pkg::RESULT_LIMIT);
    localparam logic [BKW-1:0] BKT_MAX   = BKW'(BUCKET_DEPTH - 1);

    logic [2:0]          r_bucket_bits;
    logic [1:0]          r_op;
    logic [63:0]         r_key;
    logic [63:0]         r_pp0;
    logic [31:0]         r_pp1;
    logic [31:0]         r_pp2;
    logic [63:0]         r_v;
    logic [BKW-1:0]      r_bkt;
    logic                r_hv;
    logic [BUCKET_DEPTH-1:0] r_hvalid;
    logic [RW-1:0]       r_cur;
    logic [RW:0]         r_steps;
    logic [NMW-1:0]      r_nmatch;
    logic                r_pend;
    logic [RW-1:0]       r_pend_row;
    logic [RW:0]         r_build_cnt;
    logic [31:0]         r_probe_cnt;

    logic                r_o_valid;
    logic [31:0]         r_o_left;
    logic [5:0]          r_o_right;
    logic                r_o_matched;
    logic                r_o_last;
    logic [1:0]          r_o_status;

    logic [63:0]    mul_a;
    logic [63:0]    mul_b;
    logic [63:0]    hash;
    logic [2:0]     eff_bits;
    logic [BKW-1:0] bkt_mask;
    logic [BKW-1:0] bucket_c;
    logic [RW-1:0]  row;
    logic [RW-1:0]  head_q;
    logic [RW:0]    link_q;
    logic [63:0]    key_q;
    logic           hit;

    // shared 64x64 low product, split into three 32x32 partials
    always_comb begin
        if (i_cmd.mul_sel) begin
            mul_a = r_v ^ (r_v >> hije_pkg::MIX_SH2);
            mul_b = hije_pkg::MIX_C2;
        end else begin
            mul_a = r_key ^ (r_key >> hije_pkg::MIX_SH1);
            mul_b = hije_pkg::MIX_C1;
        end
    end

    assign hash     = r_v ^ (r_v >> hije_pkg::MIX_SH3);
    assign eff_bits = (r_bucket_bits < 3'(hije_pkg::MIN_BUCKET_BITS))
                    ? 3'(hije_pkg::MIN_BUCKET_BITS) : r_bucket_bits;

    always_comb begin
        for (int i = 0; i < BKW; i++) begin
            bkt_mask[i] = (i < int'(eff_bits));
        end
    end

    assign bucket_c = hash[BKW-1:0] & bkt_mask & BKT_MAX;
    assign row      = r_build_cnt[RW-1:0];
    assign hit      = (key_q == r_key) && (r_nmatch < NM_LIMIT);

    hije_ram #(.WIDTH(RW), .DEPTH(BUCKET_DEPTH)) u_heads (
        .i_clk   (i_clk),
        .i_we    (i_cmd.build_wr),
        .i_waddr (r_bkt),
        .i_wdata (row),
        .i_raddr (bucket_c),
        .o_rdata (head_q)
    );

    hije_ram #(.WIDTH(RW + 1), .DEPTH(ROW_DEPTH)) u_links (
        .i_clk   (i_clk),
        .i_we    (i_cmd.build_wr),
        .i_waddr (row),
        .i_wdata ({r_hv, head_q}),
        .i_raddr (r_cur),
        .o_rdata (link_q)
    );

    hije_ram #(.WIDTH(64), .DEPTH(ROW_DEPTH)) u_keys (
        .i_clk   (i_clk),
        .i_we    (i_cmd.build_wr),
        .i_waddr (row),
        .i_wdata (r_key),
        .i_raddr (r_cur),
        .o_rdata (key_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_bits <= hije_pkg::BUCKET_BITS_RST;
            r_hvalid      <= '0;
            r_build_cnt   <= '0;
            r_probe_cnt   <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bucket_bits <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_hvalid    <= '0;
                r_build_cnt <= '0;
                r_probe_cnt <= '0;
            end else begin
                if (i_cmd.build_wr) begin
                    r_hvalid[r_bkt] <= 1'b1;
                    r_build_cnt     <= r_build_cnt + 1'b1;
                end
                if (i_cmd.fin) begin
                    r_probe_cnt <= r_probe_cnt + 1'b1;
                end
            end
            r_o_valid <= i_cmd.emit_full | i_cmd.emit_exh | i_cmd.build_wr | i_cmd.fin
                       | (i_cmd.cmp & hit & r_pend);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_key <= i_key;
        end
        if (i_cmd.mul) begin
            r_pp0 <= mul_a[31:0] * mul_b[31:0];
            r_pp1 <= 32'(mul_a[63:32] * mul_b[31:0]);
            r_pp2 <= 32'(mul_a[31:0] * mul_b[63:32]);
        end
        if (i_cmd.sum) begin
            r_v <= r_pp0 + {r_pp1 + r_pp2, 32'd0};
        end
        if (i_cmd.bucket) begin
            r_bkt <= bucket_c;
            r_hv  <= r_hvalid[bucket_c];
        end
        if (i_cmd.walk_init) begin
            r_cur    <= head_q;
            r_steps  <= '0;
            r_nmatch <= '0;
            r_pend   <= 1'b0;
        end
        if (i_cmd.cmp) begin
            r_cur   <= link_q[RW-1:0];
            r_steps <= r_steps + 1'b1;
            if (hit) begin
                r_pend     <= 1'b1;
                r_pend_row <= r_cur;
                r_nmatch   <= r_nmatch + 1'b1;
            end
        end

        // one result a cycle at most; a match is held until the next tells if it is last
        priority if (i_cmd.emit_full) begin
            r_o_left    <= '0;
            r_o_right   <= '0;
            r_o_matched <= 1'b0;
            r_o_last    <= 1'b1;
            r_o_status  <= hije_pkg::ST_FULL;
        end else if (i_cmd.emit_exh) begin
            r_o_left    <= r_probe_cnt;
            r_o_right   <= '0;
            r_o_matched <= 1'b0;
            r_o_last    <= 1'b1;
            r_o_status  <= hije_pkg::ST_EXHAUSTED;
        end else if (i_cmd.build_wr) begin
            r_o_left    <= '0;
            r_o_right   <= 6'(row);
            r_o_matched <= 1'b0;
            r_o_last    <= 1'b1;
            r_o_status  <= hije_pkg::ST_OK;
        end else if (i_cmd.cmp) begin
            r_o_left    <= r_probe_cnt;
            r_o_right   <= 6'(r_pend_row);
            r_o_matched <= 1'b1;
            r_o_last    <= 1'b0;
            r_o_status  <= hije_pkg::ST_OK;
        end else if (i_cmd.fin) begin
            r_o_left    <= r_probe_cnt;
            r_o_right   <= r_pend ? 6'(r_pend_row) : 6'd0;
            r_o_matched <= r_pend;
            r_o_last    <= 1'b1;
            r_o_status  <= hije_pkg::ST_OK;
        end else begin
            r_o_left <= r_o_left;
        end
    end

    assign o_sts.full       = (r_build_cnt == ROW_FULL);
    assign o_sts.exhausted  = (r_probe_cnt == 32'hFFFF_FFFF);
    assign o_sts.is_build   = (r_op == hije_pkg::OP_BUILD);
    assign o_sts.head_valid = r_hv;
    assign o_sts.more       = link_q[RW] && (r_steps < STEP_LAST);

    assign o_valid       = r_o_valid;
    assign o_left_index  = r_o_left;
    assign o_right_index = r_o_right;
    assign o_matched     = r_o_matched;
    assign o_last        = r_o_last;
    assign o_status      = r_o_status;

endmodule

/* bench/hash_inner_join_engine_test.sv */
// ----------------------------------------------------------------------------
// hash_inner_join_engine_test
// self-checking bench: random build/probe/clear requests with duplicate-heavy
// keys, bucket width changes between phases, results checked against a model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hash_inner_join_engine_test;

    localparam int ROWS    = 64;
    localparam int BUCKETS = 128;
    localparam logic K_REQ = 1'b0;
    localparam logic K_CFG = 1'b1;
    localparam logic [1:0] OP_BAD = 2'd3;
    localparam logic [31:0] PROBE_LIMIT = 32'hFFFF_FFFF;

    typedef struct {
        logic        kind;
        logic [1:0]  op;
        logic [63:0] key;
        logic [2:0]  bits;
    } t_req;

    typedef struct {
        logic [31:0] left_idx;
        logic [5:0]  right_idx;
        logic        matched;
        logic        last;
        logic [1:0]  status;
    } t_match;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_opcode = hije_pkg::OP_CLEAR;
    logic signed [63:0] i_key = '0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_wdata = '0;
    logic               o_valid;
    logic [31:0]        o_left_index;
    logic [5:0]         o_right_index;
    logic               o_matched;
    logic               o_last;
    logic [1:0]         o_status;

    hash_inner_join_engine DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_key(i_key),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_left_index(o_left_index),
        .o_right_index(o_right_index), .o_matched(o_matched),
        .o_last(o_last), .o_status(o_status)
    );

    // table shadow
    logic [2:0]  tbl_bits = hije_pkg::BUCKET_BITS_RST;
    logic [6:0]  tbl_head [BUCKETS] = '{default: '0};
    logic        tbl_head_ok [BUCKETS] = '{default: 1'b0};
    logic [6:0]  tbl_link [ROWS] = '{default: '0};
    logic        tbl_link_ok [ROWS] = '{default: 1'b0};
    logic [63:0] tbl_key [ROWS] = '{default: '0};
    int          tbl_rows = 0;
    logic [31:0] tbl_probes = '0;

    t_req   pending_q[$];
    t_match match_q[$];
    t_req   cur_req;
    int     gap_left = 0;
    int     settle = 0;
    bit     gappy = 1'b1;
    int     n_err = 0;
    logic [63:0] key_pool[8];

    initial forever #10 i_clk = ~i_clk;

    function automatic logic [63:0] splitmix(logic [63:0] v);
        v = v ^ (v >> hije_pkg::MIX_SH1);
        v = v * hije_pkg::MIX_C1;
        v = v ^ (v >> hije_pkg::MIX_SH2);
        v = v * hije_pkg::MIX_C2;
        return v ^ (v >> hije_pkg::MIX_SH3);
    endfunction

    function automatic int bucket_sel(logic [63:0] k);
        int b;
        logic [63:0] mask;
        b = (tbl_bits < 3) ? 3 : tbl_bits;
        mask = ((64'd1 << b) - 1) & (BUCKETS - 1);
        return int'(splitmix(k) & mask);
    endfunction

    function automatic void push_match(logic [31:0] l, logic [5:0] r, logic m,
                                       logic la, logic [1:0] s);
        t_match e;
        e.left_idx = l; e.right_idx = r; e.matched = m; e.last = la; e.status = s;
        match_q.push_back(e);
    endfunction

    function automatic void join_predict(t_req q);
        int b, cur, steps, n;
        bit ok;
        case (q.op)
            hije_pkg::OP_CLEAR: begin
                for (int i = 0; i < BUCKETS; i++) tbl_head_ok[i] = 1'b0;
                tbl_rows = 0;
                tbl_probes = '0;
            end
            hije_pkg::OP_BUILD: begin
                if (tbl_rows >= ROWS) begin
                    push_match('0, '0, 1'b0, 1'b1, hije_pkg::ST_FULL);
                end else begin
                    b = bucket_sel(q.key);
                    tbl_key[tbl_rows] = q.key;
                    tbl_link[tbl_rows] = tbl_head[b];
                    tbl_link_ok[tbl_rows] = tbl_head_ok[b];
                    tbl_head[b] = tbl_rows[6:0];
                    tbl_head_ok[b] = 1'b1;
                    push_match('0, tbl_rows[5:0], 1'b0, 1'b1, hije_pkg::ST_OK);
                    tbl_rows++;
                end
            end
            hije_pkg::OP_PROBE: begin
                if (tbl_probes == PROBE_LIMIT) begin
                    push_match(tbl_probes, '0, 1'b0, 1'b1, hije_pkg::ST_EXHAUSTED);
                end else begin
                    b = bucket_sel(q.key);
                    cur = tbl_head[b];
                    ok = tbl_head_ok[b];
                    steps = 0;
                    n = 0;
                    while (ok && cur < ROWS && steps < ROWS) begin
                        if (tbl_key[cur] == q.key && n < hije_pkg::RESULT_LIMIT) begin
                            push_match(tbl_probes, cur[5:0], 1'b1, 1'b0, hije_pkg::ST_OK);
                            n++;
                        end
                        ok = tbl_link_ok[cur];
                        cur = tbl_link[cur];
                        steps++;
                    end
                    if (n == 0) push_match(tbl_probes, '0, 1'b0, 1'b1, hije_pkg::ST_OK);
                    else match_q[match_q.size() - 1].last = 1'b1;
                    tbl_probes++;
                end
            end
            default: ;
        endcase
    endfunction

    // request driver
    always @(posedge i_clk) begin
        logic nxt_start, nxt_we;
        t_req q;
        nxt_start = start;
        nxt_we = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                join_predict(cur_req);
                nxt_start = 1'b0;
            end
            if (!busy && !start && match_q.size() == 0) settle++;
            else settle = 0;
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    if (pending_q[0].kind == K_CFG) begin
                        // let any trailing clear or ignored request drain first
                        if (!start && settle >= 40) begin
                            q = pending_q.pop_front();
                            nxt_we = 1'b1;
                            i_cfg_wdata <= q.bits;
                            tbl_bits = q.bits;
                        end
                    end else begin
                        cur_req = pending_q.pop_front();
                        i_opcode <= cur_req.op;
                        i_key <= cur_req.key;
                        nxt_start = 1'b1;
                        if ($urandom_range(0, 15) == 0) gappy = !gappy;
                        gap_left = gappy ? $urandom_range(0, 13) : 0;
                    end
                end
            end
        end
        start <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // result monitor
    always @(posedge i_clk) begin
        t_match e;
        if (i_rst_n && o_valid) begin
            if (match_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result: left %0d right %0d matched %b last %b st %0d",
                             o_left_index, o_right_index, o_matched, o_last, o_status);
            end else begin
                e = match_q.pop_front();
                if (o_left_index !== e.left_idx || o_right_index !== e.right_idx ||
                    o_matched !== e.matched || o_last !== e.last ||
                    o_status !== e.status) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp l=%0d r=%0d m=%b la=%b s=%0d,",
                                 e.left_idx, e.right_idx, e.matched, e.last, e.status,
                                 " got l=%0d r=%0d m=%b la=%b s=%0d",
                                 o_left_index, o_right_index, o_matched, o_last, o_status);
                end
            end
        end
    end

    function automatic void add_req(logic [1:0] op, logic [63:0] k);
        t_req q;
        q.kind = K_REQ; q.op = op; q.key = k; q.bits = '0;
        pending_q.push_back(q);
    endfunction

    function automatic void add_cfg(logic [2:0] b);
        t_req q;
        q.kind = K_CFG; q.op = hije_pkg::OP_CLEAR; q.key = '0; q.bits = b;
        pending_q.push_back(q);
    endfunction

    function automatic logic [63:0] rnd_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_key();
        return ($urandom_range(0, 3) == 0) ? rnd_key() : key_pool[$urandom_range(0, 7)];
    endfunction

    function automatic void random_phase(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) add_req(hije_pkg::OP_BUILD, pick_key());
            else if (r < 94) add_req(hije_pkg::OP_PROBE, pick_key());
            else if (r < 97) add_req(OP_BAD, rnd_key());
            else add_req(hije_pkg::OP_CLEAR, rnd_key());
        end
    endfunction

    initial begin
        logic [2:0] cfg_seq[8];
        cfg_seq = '{3'd3, 3'd0, 3'd5, 3'd1, 3'd6, 3'd4, 3'd2, 3'd7};
        for (int i = 0; i < 8; i++) key_pool[i] = rnd_key();

        // directed: key extremes, duplicates, misses, ignored opcode, clear
        add_req(hije_pkg::OP_PROBE, 64'h0);
        add_req(hije_pkg::OP_BUILD, 64'h8000_0000_0000_0000);
        add_req(hije_pkg::OP_BUILD, 64'h7FFF_FFFF_FFFF_FFFF);
        add_req(hije_pkg::OP_BUILD, 64'h0);
        add_req(hije_pkg::OP_BUILD, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(hije_pkg::OP_BUILD, 64'h0);
        add_req(hije_pkg::OP_BUILD, 64'h0);
        add_req(hije_pkg::OP_PROBE, 64'h0);
        add_req(hije_pkg::OP_PROBE, 64'h8000_0000_0000_0000);
        add_req(hije_pkg::OP_PROBE, 64'h7FFF_FFFF_FFFF_FFFF);
        add_req(hije_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(hije_pkg::OP_PROBE, 64'h1);
        add_req(OP_BAD, 64'h0);
        add_req(hije_pkg::OP_PROBE, 64'h0);
        add_req(hije_pkg::OP_CLEAR, 64'h0);
        add_req(hije_pkg::OP_PROBE, 64'h0);
        add_req(hije_pkg::OP_BUILD, 64'h5555_AAAA_5555_AAAA);
        add_req(hije_pkg::OP_PROBE, 64'h5555_AAAA_5555_AAAA);
        random_phase(4);

        // bucket width sweep, sometimes keeping stored rows across the change
        foreach (cfg_seq[i]) begin
            add_cfg(cfg_seq[i]);
            if (i % 3 != 1) add_req(hije_pkg::OP_CLEAR, '0);
            random_phase(21);
        end

        // fill past capacity with a heavily duplicated key, then probe long chains
        add_cfg(3'd3);
        add_req(hije_pkg::OP_CLEAR, '0);
        for (int i = 0; i < 66; i++)
            add_req(hije_pkg::OP_BUILD, (i % 4 == 0) ? key_pool[1] : key_pool[0]);
        add_req(hije_pkg::OP_PROBE, key_pool[0]);
        add_req(hije_pkg::OP_PROBE, key_pool[1]);
        add_req(hije_pkg::OP_PROBE, key_pool[2]);
        add_cfg(3'd7);
        add_req(hije_pkg::OP_PROBE, key_pool[0]);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || start || match_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (match_q.size() > 0) n_err++;
        if (n_err == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
